FILE: sv/wsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, constants and helpers of the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int COORD_W     = 32;
	localparam int COEF_N      = 6;
	localparam int CFG_W       = 64;
	localparam int IDX_W       = 3;
	localparam int SUM_W       = 50;
	localparam int ALT_W       = 49;
	localparam int QUO_W       = 31;
	localparam int LOW_W       = 15;
	localparam int FRAC_W      = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int W_THRESHOLD = 66;
	localparam int BEHIND_SCALE = 100000;

	typedef enum logic [IDX_W-1:0] {
		REG_X01  = 3'd0,
		REG_X23  = 3'd1,
		REG_Y01  = 3'd2,
		REG_Y23  = 3'd3,
		REG_W01  = 3'd4,
		REG_W23  = 3'd5,
		REG_MODE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_N-1:0][CFG_W-1:0] coef;
		logic                         mode;
	} wsp_cfg_t;

	// One classified point as it crosses from the front to the back.
	typedef struct packed {
		logic                    behind;
		logic                    neg_x;
		logic                    neg_y;
		logic                    ovf_x;
		logic                    ovf_y;
		logic [SUM_W-1:0]        mag_x;
		logic [SUM_W-1:0]        mag_y;
		logic [SUM_W-1:0]        den;
		logic signed [ALT_W-1:0] alt_x;
		logic signed [ALT_W-1:0] alt_y;
	} wsp_item_t;

	// Saturate a behind-point value to signed Q16.16.
	function automatic logic signed [COORD_W-1:0] sat_alt(input logic signed [ALT_W-1:0] v);
		logic signed [ALT_W-1:0] hi;
		logic signed [ALT_W-1:0] lo;
		hi = ALT_W'(signed'(33'sh0_7FFF_FFFF));
		lo = -hi - ALT_W'(1);
		if (v > hi) return {1'b0, {(COORD_W-1){1'b1}}};
		if (v < lo) return {1'b1, {(COORD_W-1){1'b0}}};
		return v[COORD_W-1:0];
	endfunction

	// Saturate a row sum to signed Q16.16.
	function automatic logic signed [COORD_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(signed'(33'sh0_7FFF_FFFF));
		lo = -hi - SUM_W'(1);
		if (v > hi) return {1'b0, {(COORD_W-1){1'b1}}};
		if (v < lo) return {1'b1, {(COORD_W-1){1'b0}}};
		return v[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/wsp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_point_if / wsp_screen_if
// Valid/ready channels for world points and screen results.
// ----------------------------------------------------------------------------
interface wsp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source(output valid, output point_x, output point_y, output point_z, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface wsp_screen_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic               behind;
	modport source(output valid, output screen_x, output screen_y, output behind, input ready);
	modport sink(input valid, input screen_x, input screen_y, input behind, output ready);
endinterface
`default_nettype wire

FILE: sv/world_to_screen_projection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of Q16.16 world points to saturated screen space.
// ----------------------------------------------------------------------------
// Stages from point transfer to result valid with an empty queue: four front
// stages, queue entry, one launch stage, 31 divider stages, output register.
// Throughput: one point per cycle when not stalled by screen back-pressure.
// Reset: asynchronous, zeroes the configuration and empties the pipes.
module world_to_screen_projection #(
	parameter int QueueDepth = wsp_pkg::QUEUE_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [wsp_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [wsp_pkg::CFG_W-1:0]    cfg_data,
	wsp_point_if.sink                         point,
	wsp_screen_if.source                      screen
);
	import wsp_pkg::*;

	wsp_cfg_t  cfg_q;
	wsp_item_t push_item, head;
	logic      push, full, pop, empty;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_X01, REG_X23, REG_Y01, REG_Y23, REG_W01, REG_W23: begin
					cfg_q.coef[cfg_index] <= cfg_data;
				end
				REG_MODE: begin
					cfg_q.mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	wsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.point     (point),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	wsp_queue #(.Depth(QueueDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	wsp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.screen (screen)
	);

endmodule
`default_nettype wire

FILE: sv/wsp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_front
// Four-stage front: row dot products, sums, classification, behind scaling, overflow check.
// ----------------------------------------------------------------------------
module wsp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wsp_pkg::wsp_cfg_t cfg,
	wsp_point_if.sink              point,
	output logic                   push,
	output wsp_pkg::wsp_item_t     push_item,
	input  wire logic              full
);
	import wsp_pkg::*;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [2*COORD_W-1:0] prod_s1 [3][3];
	logic signed [COORD_W-1:0]   trans_s1 [3];
	logic signed [SUM_W-1:0]     sum_s2 [3];
	logic                        behind_s3, neg_x_s3, neg_y_s3;
	logic [SUM_W-1:0]            mag_x_s3, mag_y_s3, den_s3;
	logic signed [COORD_W-1:0]   sat_x_s3, sat_y_s3;
	wsp_item_t                   item_s4;

	// The whole front holds while a finished item waits on a full queue.
	assign en          = !(valid_s4 && full);
	assign point.ready = en;
	assign push        = valid_s4 && !full;
	assign push_item   = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= point.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: nine coefficient by coordinate products, exact in Q32.32.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= signed'(cfg.coef[2*r][31:0]) * point.point_x;
				prod_s1[r][1] <= signed'(cfg.coef[2*r][63:32]) * point.point_y;
				prod_s1[r][2] <= signed'(cfg.coef[2*r+1][31:0]) * point.point_z;
				trans_s1[r]   <= signed'(cfg.coef[2*r+1][63:32]);
			end
		end
	end

	// Stage 2: floor each product to Q16.16 and add the translation.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= SUM_W'(prod_s1[r][0] >>> FRAC_W) + SUM_W'(prod_s1[r][1] >>> FRAC_W)
					+ SUM_W'(prod_s1[r][2] >>> FRAC_W) + SUM_W'(trans_s1[r]);
			end
		end
	end

	// Stage 3: classify against the w threshold and split sign from magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			behind_s3 <= sum_s2[2] < SUM_W'(W_THRESHOLD);
			sat_x_s3  <= sat_sum(sum_s2[0]);
			sat_y_s3  <= sat_sum(sum_s2[1]);
			neg_x_s3  <= sum_s2[0][SUM_W-1];
			neg_y_s3  <= sum_s2[1][SUM_W-1];
			mag_x_s3  <= sum_s2[0][SUM_W-1] ? SUM_W'(-sum_s2[0]) : SUM_W'(sum_s2[0]);
			mag_y_s3  <= sum_s2[1][SUM_W-1] ? SUM_W'(-sum_s2[1]) : SUM_W'(sum_s2[1]);
			den_s3    <= SUM_W'(sum_s2[2]);
		end
	end

	// Stage 4: behind scaling and the quotient overflow check.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s4.behind <= behind_s3;
			item_s4.neg_x  <= neg_x_s3;
			item_s4.neg_y  <= neg_y_s3;
			item_s4.mag_x  <= mag_x_s3;
			item_s4.mag_y  <= mag_y_s3;
			item_s4.den    <= den_s3;
			item_s4.ovf_x  <= {15'd0, mag_x_s3} >= {den_s3, 15'd0};
			item_s4.ovf_y  <= {15'd0, mag_y_s3} >= {den_s3, 15'd0};
			if (cfg.mode) begin
				item_s4.alt_x <= ALT_W'(sat_x_s3);
				item_s4.alt_y <= ALT_W'(sat_y_s3);
			end else begin
				item_s4.alt_x <= ALT_W'(sat_x_s3 * 18'sd100000);
				item_s4.alt_y <= ALT_W'(sat_y_s3 * 18'sd100000);
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/wsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module wsp_queue #(
	parameter int Depth = wsp_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire wsp_pkg::wsp_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output wsp_pkg::wsp_item_t      head,
	output logic                    empty
);
	import wsp_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	wsp_item_t       mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign full  = count_q == CntW'(Depth);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

FILE: sv/wsp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_back
// Pipelined restoring divider, one quotient bit per stage, and result select.
// ----------------------------------------------------------------------------
module wsp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wsp_pkg::wsp_item_t head,
	input  wire logic               empty,
	output logic                    pop,
	wsp_screen_if.source            screen
);
	import wsp_pkg::*;

	logic                   en;
	logic                   valid_s [QUO_W+1];
	wsp_item_t              meta_s  [QUO_W+1];
	logic [SUM_W-1:0]       rem_x_s [QUO_W+1];
	logic [SUM_W-1:0]       rem_y_s [QUO_W+1];
	logic [QUO_W-1:0]       quo_x_s [QUO_W+1];
	logic [QUO_W-1:0]       quo_y_s [QUO_W+1];
	logic [LOW_W-1:0]       low_x_s [QUO_W+1];
	logic [LOW_W-1:0]       low_y_s [QUO_W+1];
	logic                   out_valid_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;
	logic                   out_behind_q;
	wsp_item_t              fin;
	logic [QUO_W-1:0]       qx, qy;

	// The pipe moves as one while the output register is free or drained.
	assign en  = !out_valid_q || screen.ready;
	assign pop = en && !empty;

	// Stage 0: the high numerator bits form the first partial remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else if (en) valid_s[0] <= !empty;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0]  <= head;
			rem_x_s[0] <= SUM_W'(head.mag_x[SUM_W-1:LOW_W]);
			rem_y_s[0] <= SUM_W'(head.mag_y[SUM_W-1:LOW_W]);
			low_x_s[0] <= head.mag_x[LOW_W-1:0];
			low_y_s[0] <= head.mag_y[LOW_W-1:0];
			quo_x_s[0] <= '0;
			quo_y_s[0] <= '0;
		end
	end

	// Each stage brings in one numerator bit and decides one quotient bit.
	for (genvar k = 1; k <= QUO_W; k++) begin : g_div
		logic [SUM_W:0] tx, ty;
		assign tx = {rem_x_s[k-1], low_x_s[k-1][LOW_W-1]};
		assign ty = {rem_y_s[k-1], low_y_s[k-1][LOW_W-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else if (en) valid_s[k] <= valid_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k]  <= meta_s[k-1];
				low_x_s[k] <= {low_x_s[k-1][LOW_W-2:0], 1'b0};
				low_y_s[k] <= {low_y_s[k-1][LOW_W-2:0], 1'b0};
				if (tx >= {1'b0, meta_s[k-1].den}) begin
					rem_x_s[k] <= SUM_W'(tx - {1'b0, meta_s[k-1].den});
					quo_x_s[k] <= {quo_x_s[k-1][QUO_W-2:0], 1'b1};
				end else begin
					rem_x_s[k] <= SUM_W'(tx);
					quo_x_s[k] <= {quo_x_s[k-1][QUO_W-2:0], 1'b0};
				end
				if (ty >= {1'b0, meta_s[k-1].den}) begin
					rem_y_s[k] <= SUM_W'(ty - {1'b0, meta_s[k-1].den});
					quo_y_s[k] <= {quo_y_s[k-1][QUO_W-2:0], 1'b1};
				end else begin
					rem_y_s[k] <= SUM_W'(ty);
					quo_y_s[k] <= {quo_y_s[k-1][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign fin = meta_s[QUO_W];
	assign qx  = quo_x_s[QUO_W];
	assign qy  = quo_y_s[QUO_W];

	// Output register: behind values, saturated quotients or signed quotients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= valid_s[QUO_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_behind_q <= fin.behind;
			if (fin.behind) begin
				out_x_q <= sat_alt(fin.alt_x);
				out_y_q <= sat_alt(fin.alt_y);
			end else begin
				if (fin.ovf_x) out_x_q <= fin.neg_x ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
				else out_x_q <= fin.neg_x ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
				if (fin.ovf_y) out_y_q <= fin.neg_y ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
				else out_y_q <= fin.neg_y ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
			end
		end
	end

	assign screen.valid    = out_valid_q;
	assign screen.screen_x = out_x_q;
	assign screen.screen_y = out_y_q;
	assign screen.behind   = out_behind_q;

endmodule
`default_nettype wire
